[sv/mlnp_pkg.sv]
// Shared types, constants and result helpers for the mono last-note-priority block.
package mlnp_pkg;

    localparam int NOTE_W       = 7;
    localparam int MAX_HELD_DEF = 16;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 48;

    // Event kinds as classified upstream
    localparam logic [1:0] OP_NOTE_ON  = 2'd0;
    localparam logic [1:0] OP_NOTE_OFF = 2'd1;

    typedef struct packed {
        logic [1:0]        op;
        logic [7:0]        status_byte;
        logic [NOTE_W-1:0] data_first;
        logic [6:0]        data_second;
        logic [15:0]       sample_pos;
    } item_t;

    typedef struct packed {
        logic              action;
        logic [7:0]        out_status;
        logic [6:0]        out_data_first;
        logic [6:0]        out_data_second;
        logic [15:0]       out_sample_pos;
        logic [NOTE_W-1:0] glide_note;
    } result_t;

    // Pass the event through unchanged
    function automatic result_t fwd_result(input item_t it);
        result_t r;
        r.action          = 1'b0;
        r.out_status      = it.status_byte;
        r.out_data_first  = it.data_first;
        r.out_data_second = it.data_second;
        r.out_sample_pos  = it.sample_pos;
        r.glide_note      = '0;
        return r;
    endfunction

    // Glide the voice to a note, event fields cleared
    function automatic result_t glide_result(input logic [NOTE_W-1:0] note);
        result_t r;
        r.action          = 1'b1;
        r.out_status      = '0;
        r.out_data_first  = '0;
        r.out_data_second = '0;
        r.out_sample_pos  = '0;
        r.glide_note      = note;
        return r;
    endfunction

endpackage

[sv/mlnp_stack_ram.sv]
// Held-note stack storage: one write port, one read port, registered read data.
module mlnp_stack_ram #(
    parameter int DEPTH = mlnp_pkg::MAX_HELD_DEF
) (
    input  logic                          aclk,
    input  logic                          we,
    input  logic [$clog2(DEPTH)-1:0]      waddr,
    input  logic [mlnp_pkg::NOTE_W-1:0]   wdata,
    input  logic                          re,
    input  logic [$clog2(DEPTH)-1:0]      raddr,
    output logic [mlnp_pkg::NOTE_W-1:0]   rdata
);

    logic [mlnp_pkg::NOTE_W-1:0] mem [DEPTH];
    logic [mlnp_pkg::NOTE_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge aclk) begin
        if (re) begin
            rd_data_reg <= mem[raddr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

[sv/mlnp_engine.sv]
// Sequencer that compacts, shifts and pushes the held-note stack for one event, or forwards a non-note event.
module mlnp_engine #(
    parameter int MAX_HELD = mlnp_pkg::MAX_HELD_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  mlnp_pkg::item_t                  in_item,
    output logic                             res_valid,
    input  logic                             res_ready,
    output mlnp_pkg::result_t                res,
    output logic                             mem_we,
    output logic [$clog2(MAX_HELD)-1:0]      mem_waddr,
    output logic [mlnp_pkg::NOTE_W-1:0]      mem_wdata,
    output logic                             mem_re,
    output logic [$clog2(MAX_HELD)-1:0]      mem_raddr,
    input  logic [mlnp_pkg::NOTE_W-1:0]      mem_rdata
);

    localparam int AW = $clog2(MAX_HELD);
    localparam int CW = $clog2(MAX_HELD + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_PUSH,
        ST_RESULT
    } state_t;

    state_t                      state_reg, state_next;
    mlnp_pkg::item_t             item_reg, item_next;
    mlnp_pkg::result_t           res_reg, res_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [CW-1:0]               rd_idx_reg, rd_idx_next;
    logic [CW-1:0]               wr_idx_reg, wr_idx_next;
    logic                        pend_reg, pend_next;
    logic [mlnp_pkg::NOTE_W-1:0] last_reg, last_next;
    logic                        was_empty_reg, was_empty_next;
    logic                        keep;

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_RESULT);
    assign res       = res_reg;

    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        wr_idx_next    = wr_idx_reg;
        pend_next      = 1'b0;
        last_next      = last_reg;
        was_empty_next = was_empty_reg;
        mem_we         = 1'b0;
        mem_waddr      = wr_idx_reg[AW-1:0];
        mem_wdata      = mem_rdata;
        mem_re         = 1'b0;
        mem_raddr      = rd_idx_reg[AW-1:0];
        keep           = (state_reg == ST_SHIFT) || (mem_rdata != item_reg.data_first);

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    item_next      = in_item;
                    was_empty_next = (count_reg == '0);
                    rd_idx_next    = '0;
                    wr_idx_next    = '0;
                    if (in_item.op == mlnp_pkg::OP_NOTE_ON ||
                        in_item.op == mlnp_pkg::OP_NOTE_OFF) begin
                        state_next = ST_SCAN;
                    end else begin
                        res_next   = mlnp_pkg::fwd_result(in_item);
                        state_next = ST_RESULT;
                    end
                end
            end

            ST_SCAN, ST_SHIFT: begin
                // Write back the entry read last cycle if it stays
                if (pend_reg && keep) begin
                    mem_we      = 1'b1;
                    wr_idx_next = wr_idx_reg + CW'(1);
                    last_next   = mem_rdata;
                end
                // Issue the next read, or finish the pass
                if (rd_idx_reg != count_reg) begin
                    mem_re      = 1'b1;
                    rd_idx_next = rd_idx_reg + CW'(1);
                    pend_next   = 1'b1;
                end else if (!pend_reg) begin
                    count_next = wr_idx_reg;
                    if (state_reg == ST_SHIFT) begin
                        state_next = ST_PUSH;
                    end else if (item_reg.op == mlnp_pkg::OP_NOTE_ON) begin
                        if (wr_idx_reg == CW'(MAX_HELD)) begin
                            // Stack full: drop the oldest note
                            rd_idx_next = CW'(1);
                            wr_idx_next = '0;
                            state_next  = ST_SHIFT;
                        end else begin
                            state_next = ST_PUSH;
                        end
                    end else begin
                        res_next   = (wr_idx_reg != '0) ? mlnp_pkg::glide_result(last_reg)
                                                        : mlnp_pkg::fwd_result(item_reg);
                        state_next = ST_RESULT;
                    end
                end
            end

            ST_PUSH: begin
                mem_we     = 1'b1;
                mem_wdata  = item_reg.data_first;
                count_next = wr_idx_reg + CW'(1);
                res_next   = was_empty_reg ? mlnp_pkg::fwd_result(item_reg)
                                           : mlnp_pkg::glide_result(item_reg.data_first);
                state_next = ST_RESULT;
            end

            ST_RESULT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, stack depth and the registered result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
        item_reg      <= item_next;
        res_reg       <= res_next;
        rd_idx_reg    <= rd_idx_next;
        wr_idx_reg    <= wr_idx_next;
        last_reg      <= last_next;
        was_empty_reg <= was_empty_next;
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_HELD))
        else $error("held count above stack depth");

    a_write_behind_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && state_reg != ST_PUSH) |-> (wr_idx_reg < rd_idx_reg))
        else $error("compaction write reached the read pointer");

    a_push_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PUSH) |-> (wr_idx_reg < CW'(MAX_HELD)))
        else $error("push beyond stack depth");

    a_other_direct: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready && in_item.op != mlnp_pkg::OP_NOTE_ON &&
         in_item.op != mlnp_pkg::OP_NOTE_OFF) |=> (res_valid && !res.action))
        else $error("non-note event not forwarded at once");

endmodule

[sv/mono_last_note_priority_top.sv]
// Top level of the mono last-note-priority legato front end.
//
// Each beat on the slave side is one classified MIDI event, its kind on s_tuser.
// Note events walk the held-note stack in a RAM with one write and one read port:
// a compaction pass reads every held entry once (one per cycle, with registered
// read data). A note on then adds a push state, and a note on into a full stack
// runs a shift pass before the push. The block is busy for its walk plus the
// accept and result hand-off states; other events go straight from accept to
// result. The result waits in an output register, so the next event is taken
// while it is not yet consumed; with both the output register and the result
// stage full, the slave side stalls. The stack is empty after reset with no
// clearing pass.
module mono_last_note_priority_top #(
    parameter int MAX_HELD = mlnp_pkg::MAX_HELD_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // status_byte[7:0], data_first[14:8], data_second[21:15], sample_pos[37:22],
    // zero pad above
    input  logic [mlnp_pkg::S_TDATA_W-1:0] s_tdata,
    // op[1:0]: 0 note on, 1 note off, 2 or 3 other
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_status[7:0], out_data_first[14:8], out_data_second[21:15],
    // out_sample_pos[37:22], glide_note[44:38], zero pad above
    output logic [mlnp_pkg::M_TDATA_W-1:0] m_tdata,
    // action[0]: 0 forward, 1 glide
    output logic [0:0]                     m_tuser
);

    localparam int AW = $clog2(MAX_HELD);

    mlnp_pkg::item_t             in_item;
    mlnp_pkg::result_t           res;
    mlnp_pkg::result_t           m_res_reg;
    logic                        m_valid_reg;
    logic                        res_valid;
    logic                        res_ready;
    logic                        mem_we;
    logic                        mem_re;
    logic [AW-1:0]               mem_waddr;
    logic [AW-1:0]               mem_raddr;
    logic [mlnp_pkg::NOTE_W-1:0] mem_wdata;
    logic [mlnp_pkg::NOTE_W-1:0] mem_rdata;

    // Unpack the input beat
    assign in_item.op          = s_tuser;
    assign in_item.status_byte = s_tdata[7:0];
    assign in_item.data_first  = s_tdata[14:8];
    assign in_item.data_second = s_tdata[21:15];
    assign in_item.sample_pos  = s_tdata[37:22];

    mlnp_engine #(
        .MAX_HELD (MAX_HELD)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    mlnp_stack_ram #(
        .DEPTH (MAX_HELD)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Output register: load when empty or being drained
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    // Pack the output beat
    assign m_tvalid        = m_valid_reg;
    assign m_tuser         = m_res_reg.action;
    assign m_tdata[7:0]    = m_res_reg.out_status;
    assign m_tdata[14:8]   = m_res_reg.out_data_first;
    assign m_tdata[21:15]  = m_res_reg.out_data_second;
    assign m_tdata[37:22]  = m_res_reg.out_sample_pos;
    assign m_tdata[44:38]  = m_res_reg.glide_note;
    assign m_tdata[47:45]  = 3'b000;

endmodule

[verif/legato_cmd_checker.sv]
// Checker that predicts and compares voice commands of the mono last-note-priority block.
module legato_cmd_checker #(
    parameter int MAX_HELD = mlnp_pkg::MAX_HELD_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [mlnp_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [1:0]                     s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [mlnp_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [0:0]                     m_tuser,
    output int                             bad_fields,
    output int                             cmds_due
);

    // Predicted keyboard state: held notes, oldest at index 0
    logic [mlnp_pkg::NOTE_W-1:0] held_notes [MAX_HELD];
    int                          held_cnt;

    mlnp_pkg::result_t due_cmds [$];
    int                cmd_idx;

    initial begin
        bad_fields = 0;
        cmds_due   = 0;
        held_cnt   = 0;
        cmd_idx    = 0;
    end

    // Update the held-note stack for one event and work out the voice command
    task automatic follow_keyboard(input mlnp_pkg::item_t ev, output mlnp_pkg::result_t cmd);
        int                          r;
        int                          w;
        bit                          was_empty;
        bit                          glide;
        logic [mlnp_pkg::NOTE_W-1:0] target;
        glide  = 1'b0;
        target = '0;
        if (ev.op == mlnp_pkg::OP_NOTE_ON || ev.op == mlnp_pkg::OP_NOTE_OFF) begin
            was_empty = (held_cnt == 0);
            // remove any copy of the note, keep the order of the rest
            w = 0;
            for (r = 0; r < held_cnt; r++) begin
                if (held_notes[r] != ev.data_first) begin
                    held_notes[w] = held_notes[r];
                    w++;
                end
            end
            held_cnt = w;
            if (ev.op == mlnp_pkg::OP_NOTE_ON) begin
                // full stack: drop the oldest note before the push
                if (held_cnt >= MAX_HELD) begin
                    for (r = 0; r < MAX_HELD - 1; r++)
                        held_notes[r] = held_notes[r + 1];
                    held_cnt = MAX_HELD - 1;
                end
                held_notes[held_cnt] = ev.data_first;
                held_cnt++;
                glide  = !was_empty;
                target = ev.data_first;
            end else if (held_cnt > 0) begin
                glide  = 1'b1;
                target = held_notes[held_cnt - 1];
            end
        end
        cmd = '0;
        if (glide) begin
            cmd.action     = 1'b1;
            cmd.glide_note = target;
        end else begin
            cmd.out_status      = ev.status_byte;
            cmd.out_data_first  = ev.data_first;
            cmd.out_data_second = ev.data_second;
            cmd.out_sample_pos  = ev.sample_pos;
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            if (bad_fields < 10)
                $display("voice cmd %0d: %s expected %0h got %0h", cmd_idx, name, want, got);
            bad_fields++;
        end
    endtask

    always @(posedge aclk) begin
        mlnp_pkg::item_t   ev;
        mlnp_pkg::result_t got;
        mlnp_pkg::result_t want;
        if (aresetn) begin
            // compare the outgoing beat first: it belongs to an earlier event
            if (m_tvalid && m_tready) begin
                got.action          = m_tuser[0];
                got.out_status      = m_tdata[7:0];
                got.out_data_first  = m_tdata[14:8];
                got.out_data_second = m_tdata[21:15];
                got.out_sample_pos  = m_tdata[37:22];
                got.glide_note      = m_tdata[44:38];
                if (due_cmds.size() == 0) begin
                    if (bad_fields < 10)
                        $display("voice cmd %0d: beat with nothing outstanding", cmd_idx);
                    bad_fields++;
                end else begin
                    want = due_cmds.pop_front();
                    check_field("action", 16'(want.action), 16'(got.action));
                    check_field("out_status", 16'(want.out_status), 16'(got.out_status));
                    check_field("out_data_first", 16'(want.out_data_first),
                                16'(got.out_data_first));
                    check_field("out_data_second", 16'(want.out_data_second),
                                16'(got.out_data_second));
                    check_field("out_sample_pos", want.out_sample_pos, got.out_sample_pos);
                    check_field("glide_note", 16'(want.glide_note), 16'(got.glide_note));
                end
                cmd_idx++;
            end
            // predict the command for an accepted event
            if (s_tvalid && s_tready) begin
                ev.op          = s_tuser;
                ev.status_byte = s_tdata[7:0];
                ev.data_first  = s_tdata[14:8];
                ev.data_second = s_tdata[21:15];
                ev.sample_pos  = s_tdata[37:22];
                follow_keyboard(ev, want);
                due_cmds = {due_cmds, want};
            end
            cmds_due = due_cmds.size();
        end
    end

endmodule

[verif/tb.sv]
// Testbench top: drives MIDI events into the legato block and gives the verdict.
module tb;

    localparam int         MAX_HELD    = mlnp_pkg::MAX_HELD_DEF;
    localparam int         EVENT_TOTAL = 750;
    localparam int         HOLD_CYCLES = 400;
    localparam logic [1:0] OP_OTHER    = 2'd2;
    localparam logic [1:0] OP_SPARE    = 2'd3;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [mlnp_pkg::S_TDATA_W-1:0] s_tdata;
    logic [1:0]                     s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [mlnp_pkg::M_TDATA_W-1:0] m_tdata;
    logic [0:0]                     m_tuser;

    int bad_fields;
    int cmds_due;
    int events_sent;
    bit flood;
    bit no_gaps;

    mono_last_note_priority_top #(.MAX_HELD(MAX_HELD)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    legato_cmd_checker #(.MAX_HELD(MAX_HELD)) chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .bad_fields (bad_fields),
        .cmds_due   (cmds_due)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Idle before a beat: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (flood || no_gaps) return 0;
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(15, 50);
    endfunction

    // Offer one event and hold it until the block takes it
    task automatic send_event(input logic [1:0] op, input logic [7:0] status,
                              input logic [6:0] d1, input logic [6:0] d2,
                              input logic [15:0] pos);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, pos, d2, d1, status};
        do @(posedge aclk); while (!s_tready);
        events_sent++;
    endtask

    // Receiver: random ready pattern, plus one long hold-off on request
    initial begin
        int r;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            r = $urandom_range(0, 99);
            if (flood) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                flood = 1'b0;
            end else if (r < 55) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end else if (r < 95) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat ($urandom_range(20, 60)) @(posedge aclk);
            end
        end
    end

    // Stimulus and verdict
    initial begin
        int         k;
        int         seg_len;
        int         pool_size;
        int         pool_base;
        int         on_pct;
        int         r;
        logic [1:0] op;
        logic [6:0] note;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        flood       = 1'b0;
        no_gaps     = 1'b0;
        events_sent = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Pass-through events with field extremes, including the unused op code
        send_event(OP_OTHER, 8'hFF, 7'h7F, 7'h7F, 16'hFFFF);
        send_event(OP_SPARE, 8'h00, 7'h00, 7'h00, 16'h0000);
        // Release on an empty stack
        send_event(mlnp_pkg::OP_NOTE_OFF, 8'h80, 7'd127, 7'd0, 16'h00A5);
        // Fresh attack, then legato glide, then retrigger of a held note
        send_event(mlnp_pkg::OP_NOTE_ON, 8'h90, 7'd0, 7'd127, 16'h1234);
        send_event(mlnp_pkg::OP_NOTE_ON, 8'h9F, 7'd127, 7'd1, 16'hFFFF);
        send_event(mlnp_pkg::OP_NOTE_ON, 8'h90, 7'd0, 7'd64, 16'h0001);
        // Release of a note not held while others are held
        send_event(mlnp_pkg::OP_NOTE_OFF, 8'h80, 7'd5, 7'd0, 16'h8000);
        // Drop the newest, glide back; drop the last, true release
        send_event(mlnp_pkg::OP_NOTE_OFF, 8'h80, 7'd0, 7'd0, 16'h0002);
        send_event(mlnp_pkg::OP_NOTE_OFF, 8'h8F, 7'd127, 7'd127, 16'h7FFF);
        // Fill the stack past capacity so the oldest note falls out
        for (k = 0; k <= MAX_HELD; k++)
            send_event(mlnp_pkg::OP_NOTE_ON, 8'h90, 7'(40 + k), 7'(k * 7), 16'(k * 4099));

        // Random segments of playing; start with a long output hold-off
        flood = 1'b1;
        while (events_sent < EVENT_TOTAL) begin
            seg_len = $urandom_range(8, 40);
            r = $urandom_range(0, 9);
            if (r < 5) begin
                pool_size = $urandom_range(2, 8);
                on_pct    = $urandom_range(35, 65);
            end else if (r < 8) begin
                // wide pool, note-on heavy: pushes the stack into overflow
                pool_size = $urandom_range(17, 28);
                on_pct    = $urandom_range(60, 85);
            end else begin
                pool_size = 128;
                on_pct    = $urandom_range(25, 75);
            end
            pool_base = $urandom_range(0, 128 - pool_size);
            no_gaps   = ($urandom_range(0, 3) == 0);
            for (k = 0; k < seg_len && events_sent < EVENT_TOTAL; k++) begin
                r    = $urandom_range(0, 99);
                note = 7'(pool_base + $urandom_range(0, pool_size - 1));
                if (r < 2) begin
                    op   = OP_SPARE;
                    note = 7'($urandom_range(0, 127));
                end else if (r < 10) begin
                    op   = OP_OTHER;
                    note = 7'($urandom_range(0, 127));
                end else if ($urandom_range(0, 99) < on_pct) begin
                    op = mlnp_pkg::OP_NOTE_ON;
                end else begin
                    op = mlnp_pkg::OP_NOTE_OFF;
                end
                send_event(op, 8'($urandom_range(0, 255)), note,
                           7'($urandom_range(0, 127)), 16'($urandom_range(0, 65535)));
            end
        end
        s_tvalid <= 1'b0;
        no_gaps = 1'b0;

        // Let the checker record the last beat, drain, then wait for any stray beat
        @(posedge aclk);
        while (cmds_due != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (bad_fields == 0) begin
            $display("mono_last_note_priority_top verification clean");
        end else begin
            $display("mono_last_note_priority_top verification failed");
        end
        $finish;
    end

    // Run limit
    initial begin
        #6000000;
        $display("mono_last_note_priority_top verification failed");
        $finish;
    end

endmodule
